// ----- hdl/dsv_pkg.sv -----
// ----------------------------------------------------------------------------
// dsv_pkg
// Shared constants, types and helpers for the DD.MM.YYYY date checker.
// ----------------------------------------------------------------------------
`default_nettype none

package dsv_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned POS_W   = 4;
    localparam int unsigned DAY_W   = 7;
    localparam int unsigned MONTH_W = 7;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned PAIR_W  = 7;
    localparam int unsigned MDAYS_W = 5;

    localparam logic [POS_W-1:0]  DATE_LEN     = 4'd10;
    localparam logic [POS_W-1:0]  POS_MAX      = 4'd15;
    localparam logic [POS_W-1:0]  DOT_POS_A    = 4'd2;
    localparam logic [POS_W-1:0]  DOT_POS_B    = 4'd5;
    localparam logic [POS_W-1:0]  YEAR_LO_POS  = 4'd8;

    localparam logic [CHAR_W-1:0] DOT_CHAR   = 8'h2E;
    localparam logic [CHAR_W-1:0] DIGIT_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] DIGIT_NINE = 8'h39;

    localparam logic [YEAR_W-1:0] YEAR_LOWEST_RESET  = 14'd1900;
    localparam logic [YEAR_W-1:0] YEAR_HIGHEST_RESET = 14'd2100;

    localparam logic [MONTH_W-1:0] MONTH_FIRST = 7'd1;
    localparam logic [MONTH_W-1:0] MONTH_LAST  = 7'd12;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = YEAR_W;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_YEAR_LOWEST  = 1'b0,
        REG_YEAR_HIGHEST = 1'b1
    } cfg_reg_t;

    // Parsed string, handed from the parser to the checker
    typedef struct packed {
        logic               len_ok;
        logic               fmt_ok;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [PAIR_W-1:0]  century;
        logic [PAIR_W-1:0]  year_lo;
    } date_rec_t;

    function automatic logic [PAIR_W-1:0] acc7(input logic [PAIR_W-1:0] v,
                                               input logic [3:0] d);
        return PAIR_W'(v * 7'd10 + {3'b000, d});
    endfunction

    function automatic logic [YEAR_W-1:0] acc14(input logic [YEAR_W-1:0] v,
                                                input logic [3:0] d);
        return YEAR_W'(v * 14'd10 + {10'd0, d});
    endfunction

    function automatic logic [MDAYS_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [MDAYS_W-1:0] n;
        unique case (m)
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: n = 5'd31;
            7'd4, 7'd6, 7'd9, 7'd11:                    n = 5'd30;
            7'd2:                                       n = leap ? 5'd29 : 5'd28;
            default:                                    n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/date_string_validator_core.sv -----
// m_tvalid rises once the last byte of a string has passed the parser's record register
// and then the result register; m_tready low can hold the record between the two.
// Throughput: one byte per cycle while s_tready is high; s_tready drops while a parsed
// record waits for the checker, and the parser takes the next string while a result waits.
// Reset (rst_n low, asynchronous) empties the pipeline, clears the parser state
// and loads the year bounds 1900 and 2100.
// ----------------------------------------------------------------------------
// date_string_validator_core
// Checks a DD.MM.YYYY byte stream and reports the parsed Gregorian date.
// ----------------------------------------------------------------------------
`default_nettype none

module date_string_validator_core
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,  // [7:0] char_code
    input  wire logic                             s_tlast,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [31:0]                           m_tdata,  // [6:0] day_value,
                                                            // [13:7] month_value,
                                                            // [27:14] year_value
    output logic [0:0]                            m_tuser,  // [0] date_ok
    input  wire logic                             cfg_we,
    input  wire logic [dsv_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [dsv_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    logic [dsv_pkg::YEAR_W-1:0]  year_lowest_reg;
    logic [dsv_pkg::YEAR_W-1:0]  year_highest_reg;
    logic                        in_take;
    logic                        rec_take;
    logic                        rec_valid;
    dsv_pkg::date_rec_t          rec;
    logic                        date_ok;
    logic [dsv_pkg::DAY_W-1:0]   day_value;
    logic [dsv_pkg::MONTH_W-1:0] month_value;
    logic [dsv_pkg::YEAR_W-1:0]  year_value;

    assign in_take = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_lowest_reg  <= dsv_pkg::YEAR_LOWEST_RESET;
            year_highest_reg <= dsv_pkg::YEAR_HIGHEST_RESET;
        end
        else if (cfg_we)
        begin
            unique case (dsv_pkg::cfg_reg_t'(cfg_index))
                dsv_pkg::REG_YEAR_LOWEST:  year_lowest_reg  <= cfg_wdata;
                dsv_pkg::REG_YEAR_HIGHEST: year_highest_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    dsv_parse u_parse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_take   (in_take),
        .char_code (s_tdata),
        .is_last   (s_tlast),
        .rec_take  (rec_take),
        .rec_valid (rec_valid),
        .rec       (rec),
        .ready     (s_tready)
    );

    dsv_check u_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .rec_valid    (rec_valid),
        .rec          (rec),
        .year_lowest  (year_lowest_reg),
        .year_highest (year_highest_reg),
        .out_ready    (m_tready),
        .rec_take     (rec_take),
        .out_valid    (m_tvalid),
        .date_ok      (date_ok),
        .day_value    (day_value),
        .month_value  (month_value),
        .year_value   (year_value)
    );

    assign m_tdata = {4'b0000, year_value, month_value, day_value};
    assign m_tuser = date_ok;

`ifndef ASSERT_OFF
    a_last_makes_record: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && s_tlast |=> rec_valid)
        else $error("last byte did not produce a parsed record");

    a_record_held: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && !rec_take |=> rec_valid && $stable(rec))
        else $error("parsed record lost while waiting");

    a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == 32'd0)
        else $error("rejected date carries nonzero fields");

    a_good_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[6:0] != 7'd0 && m_tdata[13:7] != 7'd0
                                   && m_tdata[13:7] <= 7'd12 && m_tdata[6:0] <= 7'd31)
        else $error("accepted date out of calendar range");
`endif

endmodule

`default_nettype wire

// ----- hdl/dsv_parse.sv -----
// ----------------------------------------------------------------------------
// dsv_parse
// Per-byte format check and decimal accumulation; latches the parsed string.
// ----------------------------------------------------------------------------
`default_nettype none

module dsv_parse
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_take,
    input  wire logic [dsv_pkg::CHAR_W-1:0] char_code,
    input  wire logic                       is_last,
    input  wire logic                       rec_take,
    output logic                            rec_valid,
    output dsv_pkg::date_rec_t              rec,
    output logic                            ready
);

    logic [dsv_pkg::POS_W-1:0]   pos_reg,     pos_next;
    logic                        fmt_reg,     fmt_next;
    logic [dsv_pkg::DAY_W-1:0]   day_reg,     day_next;
    logic [dsv_pkg::MONTH_W-1:0] month_reg,   month_next;
    logic [dsv_pkg::YEAR_W-1:0]  year_reg,    year_next;
    logic [dsv_pkg::PAIR_W-1:0]  century_reg, century_next;
    logic [dsv_pkg::PAIR_W-1:0]  ylo_reg,     ylo_next;
    logic                        rec_valid_reg, rec_valid_next;
    dsv_pkg::date_rec_t          rec_reg;
    logic                        is_digit;
    logic [3:0]                  digit;
    logic                        load_rec;

    assign is_digit = (char_code >= dsv_pkg::DIGIT_ZERO) && (char_code <= dsv_pkg::DIGIT_NINE);
    assign digit    = char_code[3:0];
    assign load_rec = in_take && is_last;
    assign ready    = !rec_valid_reg || rec_take;

    always_comb
    begin
        pos_next     = pos_reg;
        fmt_next     = fmt_reg;
        day_next     = day_reg;
        month_next   = month_reg;
        year_next    = year_reg;
        century_next = century_reg;
        ylo_next     = ylo_reg;
        if (in_take)
        begin
            if (pos_reg < dsv_pkg::DATE_LEN)
            begin
                if (pos_reg == dsv_pkg::DOT_POS_A || pos_reg == dsv_pkg::DOT_POS_B)
                begin
                    if (char_code != dsv_pkg::DOT_CHAR)
                        fmt_next = 1'b0;
                end
                else if (!is_digit)
                begin
                    fmt_next = 1'b0;
                end
                else if (pos_reg < dsv_pkg::DOT_POS_A)
                begin
                    day_next = dsv_pkg::acc7(day_reg, digit);
                end
                else if (pos_reg < dsv_pkg::DOT_POS_B)
                begin
                    month_next = dsv_pkg::acc7(month_reg, digit);
                end
                else
                begin
                    year_next = dsv_pkg::acc14(year_reg, digit);
                    if (pos_reg < dsv_pkg::YEAR_LO_POS)
                        century_next = dsv_pkg::acc7(century_reg, digit);
                    else
                        ylo_next = dsv_pkg::acc7(ylo_reg, digit);
                end
            end
            if (pos_reg < dsv_pkg::POS_MAX)
                pos_next = pos_reg + 4'd1;
        end
    end

    always_comb
    begin
        rec_valid_next = rec_valid_reg;
        if (rec_take)
            rec_valid_next = 1'b0;
        if (load_rec)
            rec_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            fmt_reg       <= 1'b1;
            day_reg       <= '0;
            month_reg     <= '0;
            year_reg      <= '0;
            century_reg   <= '0;
            ylo_reg       <= '0;
            rec_valid_reg <= 1'b0;
        end
        else
        begin
            rec_valid_reg <= rec_valid_next;
            if (load_rec)
            begin
                pos_reg     <= '0;
                fmt_reg     <= 1'b1;
                day_reg     <= '0;
                month_reg   <= '0;
                year_reg    <= '0;
                century_reg <= '0;
                ylo_reg     <= '0;
            end
            else
            begin
                pos_reg     <= pos_next;
                fmt_reg     <= fmt_next;
                day_reg     <= day_next;
                month_reg   <= month_next;
                year_reg    <= year_next;
                century_reg <= century_next;
                ylo_reg     <= ylo_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_rec)
        begin
            rec_reg.len_ok  <= (pos_next == dsv_pkg::DATE_LEN);
            rec_reg.fmt_ok  <= fmt_next;
            rec_reg.day     <= day_next;
            rec_reg.month   <= month_next;
            rec_reg.year    <= year_next;
            rec_reg.century <= century_next;
            rec_reg.year_lo <= ylo_next;
        end
    end

    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

endmodule

`default_nettype wire

// ----- hdl/dsv_check.sv -----
// ----------------------------------------------------------------------------
// dsv_check
// Range and calendar check of a parsed date; holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dsv_check
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        rec_valid,
    input  wire dsv_pkg::date_rec_t          rec,
    input  wire logic [dsv_pkg::YEAR_W-1:0]  year_lowest,
    input  wire logic [dsv_pkg::YEAR_W-1:0]  year_highest,
    input  wire logic                        out_ready,
    output logic                             rec_take,
    output logic                             out_valid,
    output logic                             date_ok,
    output logic [dsv_pkg::DAY_W-1:0]        day_value,
    output logic [dsv_pkg::MONTH_W-1:0]      month_value,
    output logic [dsv_pkg::YEAR_W-1:0]       year_value
);

    logic                          out_valid_reg, out_valid_next;
    logic                          ok_reg;
    logic [dsv_pkg::DAY_W-1:0]     day_reg;
    logic [dsv_pkg::MONTH_W-1:0]   month_reg;
    logic [dsv_pkg::YEAR_W-1:0]    year_reg;
    logic                          leap;
    logic [dsv_pkg::MDAYS_W-1:0]   mdays;
    logic                          ok;

    // leap: year divisible by 4 and not by 100, or by 400
    assign leap = ((rec.year_lo != '0) && (rec.year_lo[1:0] == 2'b00))
               || ((rec.year_lo == '0) && (rec.century[1:0] == 2'b00));
    assign mdays = dsv_pkg::month_days(rec.month, leap);

    assign ok = rec.len_ok && rec.fmt_ok
             && (rec.year >= year_lowest) && (rec.year <= year_highest)
             && (rec.month >= dsv_pkg::MONTH_FIRST) && (rec.month <= dsv_pkg::MONTH_LAST)
             && (rec.day != '0) && (rec.day <= {2'b00, mdays});

    assign rec_take = rec_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        if (rec_take)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (rec_take)
        begin
            ok_reg    <= ok;
            day_reg   <= ok ? rec.day   : '0;
            month_reg <= ok ? rec.month : '0;
            year_reg  <= ok ? rec.year  : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign date_ok     = ok_reg;
    assign day_value   = day_reg;
    assign month_value = month_reg;
    assign year_value  = year_reg;

endmodule

`default_nettype wire
